@@ design/udps_pkg.sv @@
// ----------------------------------------------------------------------------
// udps_pkg
// Shared types and constants for the up/down digital potentiometer stepper.
// ----------------------------------------------------------------------------
package udps_pkg;

  localparam int unsigned POS_W   = 7;
  localparam int unsigned STEP_W  = 8;
  localparam int unsigned DELAY_W = 16;
  localparam int unsigned CFG_W   = 16;

  localparam logic [POS_W-1:0]   MAX_POSITION      = 7'd100;
  localparam logic [DELAY_W-1:0] HALF_PULSE_RESET  = 16'd20;
  localparam logic [STEP_W-1:0]  FULL_SCALE_RESET  = 8'd100;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_TARGET = 2'd1,
    OP_ZERO   = 2'd2,
    OP_NOP    = 2'd3
  } opcode_t;

  typedef enum logic {
    REG_HALF_PULSE = 1'b0,
    REG_FULL_SCALE = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_HIGH = 3'b010,
    PH_LOW  = 3'b100
  } phase_t;

  typedef struct packed {
    logic             chip_select_n;
    logic             direction_up;
    logic             increment_n;
    logic             busy_res;
    logic             accepted;
    logic [POS_W-1:0] wiper_position;
  } result_t;

endpackage

@@ design/updown_digipot_stepper.sv @@
// ----------------------------------------------------------------------------
// updown_digipot_stepper
// Sequencer for a three-wire up/down digital potentiometer (CS, U/D, INC).
// ----------------------------------------------------------------------------
//
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------------
//  in      | in_valid / in_stall    | opcode, target_position
//  out     | out_valid / out_stall  | chip_select_n, direction_up, increment_n,
//          |                        | busy_res, accepted, wiper_position
//  cfg     | cfg_write_en           | cfg_index, cfg_data
//
//  One item per cycle while in_stall is low: the sequencer state and the
//  result are computed in the same cycle the item is transferred, so a new
//  item can follow every clock. One result per item. The result register
//  plus a one-entry skid buffer let one more input transfer through after
//  the output side stalls; in_stall rises only once the skid entry is occupied.
//  Synchronous active-high reset: CS high, U/D low, INC high, position 0,
//  registers back to 20 ticks per half pulse and 100 full-scale steps.
// ----------------------------------------------------------------------------
module updown_digipot_stepper
  import udps_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         opcode,
  input  logic [POS_W-1:0]   target_position,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               chip_select_n,
  output logic               direction_up,
  output logic               increment_n,
  output logic               busy_res,
  output logic               accepted,
  output logic [POS_W-1:0]   wiper_position,
  // configuration
  input  logic               cfg_write_en,
  input  logic               cfg_index,
  input  logic [CFG_W-1:0]   cfg_data
);

  // configuration registers
  logic [DELAY_W-1:0] half_pulse_ticks;
  logic [STEP_W-1:0]  full_scale_steps;

  // sequencer state
  logic [POS_W-1:0]   position_reg,    position_reg_next;
  logic [POS_W-1:0]   pending_target,  pending_target_next;
  logic [STEP_W-1:0]  steps_remaining, steps_remaining_next;
  logic [DELAY_W-1:0] delay_count,     delay_count_next;
  phase_t             phase,           phase_next;
  logic               cs_n,            cs_n_next;
  logic               dir_up,          dir_up_next;
  logic               inc_n,           inc_n_next;
  logic               took;

  // output register and skid entry
  result_t            out_res, skid_res, res_next;
  logic               skid_valid;

  logic               in_xfer, out_xfer;
  logic [DELAY_W-1:0] half_load;
  logic [STEP_W-1:0]  steps_dec;
  logic [POS_W-1:0]   diff;
  logic               going_up;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;
  assign in_stall = skid_valid;

  // a zero half-pulse setting behaves as one tick
  assign half_load = (half_pulse_ticks == '0) ? DELAY_W'(1) : half_pulse_ticks;
  assign steps_dec = (steps_remaining != '0) ? steps_remaining - STEP_W'(1) : '0;
  assign going_up  = target_position > position_reg;
  assign diff      = going_up ? target_position - position_reg
                              : position_reg - target_position;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_pulse_ticks <= HALF_PULSE_RESET;
      full_scale_steps <= FULL_SCALE_RESET;
    end else if (cfg_write_en) begin
      unique case (reg_index_t'(cfg_index))
        REG_HALF_PULSE: half_pulse_ticks <= cfg_data;
        REG_FULL_SCALE: full_scale_steps <= cfg_data[STEP_W-1:0];
        default:        ;
      endcase
    end
  end

  // next sequencer state for the item on the input channel
  always_comb begin
    position_reg_next    = position_reg;
    pending_target_next  = pending_target;
    steps_remaining_next = steps_remaining;
    delay_count_next     = delay_count;
    phase_next           = phase;
    cs_n_next            = cs_n;
    dir_up_next          = dir_up;
    inc_n_next           = inc_n;
    took                 = 1'b0;

    unique case (opcode_t'(opcode))
      OP_TICK: begin
        if (phase != PH_IDLE) begin
          if (delay_count > DELAY_W'(1)) begin
            delay_count_next = delay_count - DELAY_W'(1);
          end else if (phase == PH_HIGH) begin
            // first half done: falling edge on INC moves the wiper
            inc_n_next       = 1'b0;
            delay_count_next = half_load;
            phase_next       = PH_LOW;
          end else begin
            inc_n_next           = 1'b1;
            steps_remaining_next = steps_dec;
            if (steps_dec == '0) begin
              // last pulse: deselect and record the position
              cs_n_next         = 1'b1;
              position_reg_next = pending_target;
              delay_count_next  = '0;
              phase_next        = PH_IDLE;
            end else begin
              delay_count_next = half_load;
              phase_next       = PH_HIGH;
            end
          end
        end
      end
      OP_TARGET: begin
        if (phase == PH_IDLE && target_position <= MAX_POSITION &&
            target_position != position_reg) begin
          cs_n_next            = 1'b0;
          dir_up_next          = going_up;
          inc_n_next           = 1'b1;
          pending_target_next  = target_position;
          steps_remaining_next = STEP_W'(diff);
          delay_count_next     = half_load;
          phase_next           = PH_HIGH;
          took                 = 1'b1;
        end
      end
      OP_ZERO: begin
        if (phase == PH_IDLE) begin
          cs_n_next            = 1'b0;
          dir_up_next          = 1'b0;
          inc_n_next           = 1'b1;
          pending_target_next  = '0;
          steps_remaining_next = (full_scale_steps == '0) ? STEP_W'(1)
                                                          : full_scale_steps;
          delay_count_next     = half_load;
          phase_next           = PH_HIGH;
          took                 = 1'b1;
        end
      end
      OP_NOP: ;
      default: ;
    endcase

    res_next.chip_select_n  = cs_n_next;
    res_next.direction_up   = dir_up_next;
    res_next.increment_n    = inc_n_next;
    res_next.busy_res       = (phase_next != PH_IDLE);
    res_next.accepted       = took;
    res_next.wiper_position = position_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position_reg    <= '0;
      pending_target  <= '0;
      steps_remaining <= '0;
      delay_count     <= '0;
      phase           <= PH_IDLE;
      cs_n            <= 1'b1;
      dir_up          <= 1'b0;
      inc_n           <= 1'b1;
    end else if (in_xfer) begin
      position_reg    <= position_reg_next;
      pending_target  <= pending_target_next;
      steps_remaining <= steps_remaining_next;
      delay_count     <= delay_count_next;
      phase           <= phase_next;
      cs_n            <= cs_n_next;
      dir_up          <= dir_up_next;
      inc_n           <= inc_n_next;
    end
  end

  // output register with one-entry skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || out_xfer) begin
        out_valid  <= skid_valid || in_xfer;
        skid_valid <= 1'b0;
      end else if (in_xfer) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_xfer) begin
      out_res <= skid_valid ? skid_res : res_next;
    end
    if (in_xfer && out_valid && !out_xfer) begin
      skid_res <= res_next;
    end
  end

  assign chip_select_n  = out_res.chip_select_n;
  assign direction_up   = out_res.direction_up;
  assign increment_n    = out_res.increment_n;
  assign busy_res       = out_res.busy_res;
  assign accepted       = out_res.accepted;
  assign wiper_position = out_res.wiper_position;

  // chip select is low exactly while a sequence runs
  a_cs_tracks_phase: assert property (@(posedge clk) disable iff (rst)
    cs_n == (phase == PH_IDLE))
    else $error("chip select out of step with sequencer phase");

  // a running sequence always has pulses left
  a_steps_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_IDLE) |-> (steps_remaining != '0))
    else $error("sequence running with no steps left");

  // skid entry only holds data behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry occupied while output register empty");

  // a zero command taken while idle always starts the high half of a pulse
  a_zero_starts: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && opcode == OP_ZERO && phase == PH_IDLE) |=>
      (phase == PH_HIGH && !cs_n && !dir_up))
    else $error("zero command did not start a down sequence");

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the up/down digital potentiometer stepper. A table
// of directed commands comes first, then phases of random command/tick
// sequences under several register settings and one run at a long half
// pulse. Every transfer on the input side is run through an in-bench model
// of the sequencer. Each output transfer is compared field by field against
// the oldest predicted pin state.
// ----------------------------------------------------------------------------
module tb_top;
  import udps_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned RAND_ITEMS  = 150;   // live items in the random part
  localparam int unsigned N_PHASES    = 6;
  localparam int unsigned N_ROWS      = 17;

  // Expected result plus the input transfer number it belongs to.
  typedef struct {
    result_t     pins;
    int unsigned item;
  } due_t;

  // One row of the directed table. When wr is set, the registers are
  // rewritten (with the block drained) before the row's command. When typed
  // is set, want is the hand-written expectation. play_out ticks the block
  // until the sequence it started is over.
  typedef struct packed {
    opcode_t          op;
    logic [POS_W-1:0] tgt;
    logic             wr;
    logic [CFG_W-1:0] half;
    logic [CFG_W-1:0] full;
    logic             typed;
    result_t          want;
    logic             play_out;
  } row_t;

  // --------------------------------------------------------------------------
  // DUT hookup. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [1:0]       opcode = OP_NOP;
  logic [POS_W-1:0] target_position = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             chip_select_n;
  logic             direction_up;
  logic             increment_n;
  logic             busy_res;
  logic             accepted;
  logic [POS_W-1:0] wiper_position;
  logic             cfg_write_en = 1'b0;
  logic             cfg_index = REG_HALF_PULSE;
  logic [CFG_W-1:0] cfg_data = '0;

  updown_digipot_stepper u_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .opcode          (opcode),
    .target_position (target_position),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .chip_select_n   (chip_select_n),
    .direction_up    (direction_up),
    .increment_n     (increment_n),
    .busy_res        (busy_res),
    .accepted        (accepted),
    .wiper_position  (wiper_position),
    .cfg_write_en    (cfg_write_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  due_t        due_pins_q[$];     // predicted results not yet seen on the output
  int unsigned mismatches = 0;
  int unsigned item_no    = 0;    // input transfers so far
  int unsigned live_items = 0;    // transfers that did something (not ignored)
  int unsigned cycles     = 0;
  logic        steady     = 1'b0; // no gaps and no stalls while set
  row_t        plan [N_ROWS];

  // --------------------------------------------------------------------------
  // Sequencer model: registers, wiper and pulse machine, kept in step with
  // the block one input transfer at a time.
  // --------------------------------------------------------------------------
  logic [DELAY_W-1:0] half_cfg;
  logic [STEP_W-1:0]  full_cfg;
  logic [POS_W-1:0]   wiper_q;
  logic [POS_W-1:0]   goal_q;
  logic [STEP_W-1:0]  steps_left;
  logic [DELAY_W-1:0] delay_left;
  phase_t             phase_q;
  logic               cs_q, dir_q, inc_q;

  // A half pulse setting of zero still lasts one tick.
  function automatic logic [DELAY_W-1:0] half_reload();
    return (half_cfg == '0) ? DELAY_W'(1) : half_cfg;
  endfunction

  // Select the part, set direction, and arm the first high half pulse.
  function automatic void launch(input logic up, input logic [STEP_W-1:0] count,
                                 input logic [POS_W-1:0] goal);
    cs_q       = 1'b0;
    dir_q      = up;
    inc_q      = 1'b1;
    goal_q     = goal;
    steps_left = (count == '0) ? STEP_W'(1) : count;
    delay_left = half_reload();
    phase_q    = PH_HIGH;
  endfunction

  // One tick of time: count down the current half, flip INC at its end,
  // and close the sequence after the last low half.
  function automatic void tick_pot();
    if (phase_q == PH_IDLE) begin
      return;
    end
    if (delay_left > 1) begin
      delay_left = delay_left - 1'b1;
    end else if (phase_q == PH_HIGH) begin
      inc_q      = 1'b0;           // falling edge moves the wiper
      delay_left = half_reload();
      phase_q    = PH_LOW;
    end else begin
      inc_q = 1'b1;
      if (steps_left != '0) begin
        steps_left = steps_left - 1'b1;
      end
      if (steps_left == '0) begin
        cs_q       = 1'b1;
        wiper_q    = goal_q;
        delay_left = '0;
        phase_q    = PH_IDLE;
      end else begin
        delay_left = half_reload();
        phase_q    = PH_HIGH;
      end
    end
  endfunction

  // Apply one command and return the pin state it leaves behind.
  function automatic result_t pot_next(input opcode_t op, input logic [POS_W-1:0] tgt);
    result_t r;
    logic    took;
    took = 1'b0;
    case (op)
      OP_TICK: begin
        tick_pot();
      end
      OP_TARGET: begin
        if (phase_q == PH_IDLE && tgt <= MAX_POSITION && tgt != wiper_q) begin
          if (tgt > wiper_q) begin
            launch(1'b1, tgt - wiper_q, tgt);
          end else begin
            launch(1'b0, wiper_q - tgt, tgt);
          end
          took = 1'b1;
        end
      end
      OP_ZERO: begin
        // taken whenever idle, even when the wiper already sits at zero
        if (phase_q == PH_IDLE) begin
          launch(1'b0, full_cfg, '0);
          took = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.chip_select_n  = cs_q;
    r.direction_up   = dir_q;
    r.increment_n    = inc_q;
    r.busy_res       = (phase_q != PH_IDLE);
    r.accepted       = took;
    r.wiper_position = wiper_q;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string line);
    mismatches++;
    $display("[%0t] MISMATCH %s", $realtime, line);
  endtask

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(3, 1);
    end
    return $urandom_range(30, 8);
  endfunction

  function automatic row_t mk_row(input opcode_t op, input int tgt, input int wr,
                                  input int half, input int full, input int typed,
                                  input result_t want, input int play_out);
    row_t r;
    r.op       = op;
    r.tgt      = POS_W'(tgt);
    r.wr       = (wr != 0);
    r.half     = CFG_W'(half);
    r.full     = CFG_W'(full);
    r.typed    = (typed != 0);
    r.want     = want;
    r.play_out = (play_out != 0);
    return r;
  endfunction

  // Offer one item, hold it until transferred, then predict its result.
  // A typed expectation replaces the predicted one but the model still steps.
  task automatic send_item(input opcode_t op, input logic [POS_W-1:0] tgt,
                           input logic typed = 1'b0, input result_t want = '0);
    int unsigned gap;
    logic        was_busy;
    result_t     pins;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    opcode          <= op;
    target_position <= tgt;
    do @(posedge clk); while (in_stall);
    item_no++;
    was_busy = (phase_q != PH_IDLE);
    pins     = pot_next(op, tgt);
    if (pins.accepted || (op == OP_TICK && was_busy)) begin
      live_items++;
    end
    due_pins_q.push_back('{pins: typed ? want : pins, item: item_no});
  endtask

  // Stop offering items and wait until every predicted result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_pins_q.size() != 0) @(posedge clk);
  endtask

  // Both registers back to back; only call with the block drained.
  task automatic set_regs(input logic [CFG_W-1:0] half_val,
                          input logic [CFG_W-1:0] full_val);
    cfg_write_en <= 1'b1;
    cfg_index    <= REG_HALF_PULSE;
    cfg_data     <= half_val;
    @(posedge clk);
    half_cfg     = half_val;
    cfg_index    <= REG_FULL_SCALE;
    cfg_data     <= full_val;
    @(posedge clk);
    full_cfg     = full_val[STEP_W-1:0];
    cfg_write_en <= 1'b0;
  endtask

  // Tick until the running sequence is over; random junk on the target pins.
  task automatic play_out();
    while (phase_q != PH_IDLE) begin
      send_item(OP_TICK, POS_W'($urandom));
    end
  endtask

  // One random command followed by the ticks it needs, with stray commands
  // thrown in while busy (the block must ignore them).
  task automatic run_episode();
    int unsigned      r;
    int unsigned      step;
    opcode_t          op;
    logic [POS_W-1:0] tgt;
    r   = $urandom_range(99, 0);
    op  = OP_TARGET;
    tgt = POS_W'($urandom);
    if (r < 60) begin
      // short move from where the wiper is now
      step = $urandom_range(4, 1);
      if ((($urandom_range(1, 0) == 1) && (wiper_q + step <= MAX_POSITION)) ||
          (wiper_q < step)) begin
        tgt = POS_W'(wiper_q + step);
      end else begin
        tgt = POS_W'(wiper_q - step);
      end
    end else if (r < 70) begin
      tgt = POS_W'($urandom_range(MAX_POSITION, 0));
    end else if (r < 78) begin
      tgt = POS_W'($urandom_range(127, MAX_POSITION + 1));    // out of range
    end else if (r < 83) begin
      tgt = wiper_q;                                           // no move
    end else if (r < 93) begin
      op = OP_ZERO;
    end else begin
      op = opcode_t'($urandom_range(1, 0) ? OP_NOP : OP_TICK); // idle noise
    end
    send_item(op, tgt);
    while (phase_q != PH_IDLE) begin
      if ($urandom_range(99, 0) < 88) begin
        send_item(OP_TICK, POS_W'($urandom));
      end else begin
        send_item(opcode_t'($urandom_range(3, 1)), POS_W'($urandom));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Output side: random stall pattern and result checking.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_side
    int unsigned stall_left;
    int unsigned run_left;
    due_t        head;
    result_t     got;
    if (!rst && out_valid && !out_stall) begin
      got = {chip_select_n, direction_up, increment_n, busy_res, accepted, wiper_position};
      if (due_pins_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: %h", got));
      end else begin
        head = due_pins_q.pop_front();
        if (got.chip_select_n !== head.pins.chip_select_n)
          report_mismatch($sformatf("item %0d chip_select_n got %b want %b", head.item,
                                    got.chip_select_n, head.pins.chip_select_n));
        if (got.direction_up !== head.pins.direction_up)
          report_mismatch($sformatf("item %0d direction_up got %b want %b", head.item,
                                    got.direction_up, head.pins.direction_up));
        if (got.increment_n !== head.pins.increment_n)
          report_mismatch($sformatf("item %0d increment_n got %b want %b", head.item,
                                    got.increment_n, head.pins.increment_n));
        if (got.busy_res !== head.pins.busy_res)
          report_mismatch($sformatf("item %0d busy_res got %b want %b", head.item,
                                    got.busy_res, head.pins.busy_res));
        if (got.accepted !== head.pins.accepted)
          report_mismatch($sformatf("item %0d accepted got %b want %b", head.item,
                                    got.accepted, head.pins.accepted));
        if (got.wiper_position !== head.pins.wiper_position)
          report_mismatch($sformatf("item %0d wiper_position got %0d want %0d", head.item,
                                    got.wiper_position, head.pins.wiper_position));
      end
    end
    // stall bursts separated by free runs; now and then a long free stretch
    if (steady) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (run_left != 0) begin
        run_left--;
      end else begin
        stall_left = pick_gap();
        run_left   = ($urandom_range(9, 0) == 0) ? $urandom_range(200, 50)
                                                 : $urandom_range(12, 0);
      end
    end
  end

  // Watchdog: a hung handshake or a missing result ends up here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [CFG_W-1:0] ph_half [N_PHASES];
    logic [CFG_W-1:0] ph_full [N_PHASES];
    logic             ph_steady [N_PHASES];
    int unsigned      live_base;
    logic [POS_W-1:0] tgt;

    // model state after reset
    half_cfg   = HALF_PULSE_RESET;
    full_cfg   = FULL_SCALE_RESET;
    wiper_q    = '0;
    goal_q     = '0;
    steps_left = '0;
    delay_left = '0;
    phase_q    = PH_IDLE;
    cs_q       = 1'b1;
    dir_q      = 1'b0;
    inc_q      = 1'b1;

    // Directed table. Typed results read {cs_n, dir_up, inc_n, busy, acc, pos}.
    // Rows 0-5 run with the reset register values (20 ticks per half, 100 steps).
    plan[0]  = mk_row(OP_TICK,   0,   0, 0, 0, 1, {1'b1,1'b0,1'b1,1'b0,1'b0,7'd0}, 0);
    plan[1]  = mk_row(OP_NOP,    127, 0, 0, 0, 1, {1'b1,1'b0,1'b1,1'b0,1'b0,7'd0}, 0);
    plan[2]  = mk_row(OP_TARGET, 101, 0, 0, 0, 1, {1'b1,1'b0,1'b1,1'b0,1'b0,7'd0}, 0);
    plan[3]  = mk_row(OP_TARGET, 127, 0, 0, 0, 1, {1'b1,1'b0,1'b1,1'b0,1'b0,7'd0}, 0);
    plan[4]  = mk_row(OP_TARGET, 0,   0, 0, 0, 1, {1'b1,1'b0,1'b1,1'b0,1'b0,7'd0}, 0);
    plan[5]  = mk_row(OP_TARGET, 1,   0, 0, 0, 1, {1'b0,1'b1,1'b1,1'b1,1'b1,7'd0}, 1);
    // zero in both registers: one tick per half, one pulse per reset
    plan[6]  = mk_row(OP_TARGET, 0,   1, 0, 0, 1, {1'b0,1'b0,1'b1,1'b1,1'b1,7'd1}, 1);
    plan[7]  = mk_row(OP_ZERO,   0,   0, 0, 0, 1, {1'b0,1'b0,1'b1,1'b1,1'b1,7'd0}, 0);
    plan[8]  = mk_row(OP_TARGET, 50,  0, 0, 0, 1, {1'b0,1'b0,1'b1,1'b1,1'b0,7'd0}, 0);
    plan[9]  = mk_row(OP_ZERO,   0,   0, 0, 0, 1, {1'b0,1'b0,1'b1,1'b1,1'b0,7'd0}, 0);
    plan[10] = mk_row(OP_NOP,    85,  0, 0, 0, 1, {1'b0,1'b0,1'b1,1'b1,1'b0,7'd0}, 0);
    plan[11] = mk_row(OP_TICK,   0,   0, 0, 0, 0, '0, 0);
    plan[12] = mk_row(OP_TICK,   0,   0, 0, 0, 0, '0, 0);
    // full travel up, out-of-range at the top, reset from the top
    plan[13] = mk_row(OP_TARGET, 100, 1, 1, 3, 1, {1'b0,1'b1,1'b1,1'b1,1'b1,7'd0}, 1);
    plan[14] = mk_row(OP_TARGET, 101, 0, 0, 0, 1, {1'b1,1'b1,1'b1,1'b0,1'b0,7'd100}, 0);
    plan[15] = mk_row(OP_ZERO,   0,   0, 0, 0, 1, {1'b0,1'b0,1'b1,1'b1,1'b1,7'd100}, 1);
    // left running: the first random phase rewrites the registers mid-sequence
    plan[16] = mk_row(OP_TARGET, 4,   0, 0, 0, 0, '0, 0);

    // Random phases: small half pulses keep sequences short; one phase with
    // a longer full scale, one with zero in both, one with junk above the
    // 8-bit full scale field, one without any idling.
    ph_half[0] = 16'd1;  ph_full[0] = 16'd3;    ph_steady[0] = 1'b0;
    ph_half[1] = 16'd0;  ph_full[1] = 16'd0;    ph_steady[1] = 1'b0;
    ph_half[2] = 16'd1;  ph_full[2] = 16'd24;   ph_steady[2] = 1'b0;
    ph_half[3] = 16'd3;  ph_full[3] = 16'd7;    ph_steady[3] = 1'b1;
    ph_half[4] = 16'd2;
    ph_full[4] = CFG_W'(($urandom_range(255, 1) << 8) | 5);
    ph_steady[4] = 1'b0;
    ph_half[5] = CFG_W'($urandom_range(3, 1));
    ph_full[5] = CFG_W'($urandom_range(8, 1));
    ph_steady[5] = 1'b0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed part ----
    foreach (plan[i]) begin
      if (plan[i].wr) begin
        drain();
        set_regs(plan[i].half, plan[i].full);
      end
      send_item(plan[i].op, plan[i].tgt, plan[i].typed, plan[i].want);
      if (plan[i].play_out) begin
        play_out();
      end
    end

    // ---- random part ----
    for (int p = 0; p < N_PHASES; p++) begin
      drain();                       // sender holds off until all results are in
      set_regs(ph_half[p], ph_full[p]);
      steady    = ph_steady[p];
      live_base = live_items;
      while (live_items - live_base < RAND_ITEMS / N_PHASES) begin
        run_episode();
      end
    end

    // ---- long half pulse ----
    // Arm one step at a long half pulse and count the high half all the
    // way down. Just before it expires, drop the half pulse to one tick so the
    // low half is short: the new value only lands at the next reload.
    steady = 1'b1;
    drain();
    set_regs(16'd40, 16'd12);
    tgt = (wiper_q == '0) ? POS_W'(1) : POS_W'(wiper_q - 1'b1);
    send_item(OP_TARGET, tgt);
    while (delay_left > 1) begin
      send_item(OP_TICK, '0);
    end
    drain();
    set_regs(16'd1, 16'd12);
    play_out();
    // full-scale reset
    send_item(OP_ZERO, POS_W'($urandom));
    play_out();
    steady = 1'b0;

    // ---- wind down ----
    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && due_pins_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
